>>> rtl/core/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and constants of the two-form PID controller
// Payload words, configuration and loop state records, register indexes and
// the saturating clamp used by both control forms.
// ----------------------------------------------------------------------------
package pidc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_MIN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_MAX = 3'd7;

	localparam logic MODE_INCR = 1'b0;
	localparam logic MODE_POS  = 1'b1;

	localparam logic signed [15:0] LIMIT_LO = 16'sh8000;
	localparam logic signed [15:0] LIMIT_HI = 16'sh7fff;

	typedef struct packed {
		logic signed [15:0] setpoint;
		logic signed [15:0] measured;
	} in_t;

	typedef struct packed {
		logic signed [16:0] error_value;
		logic signed [15:0] drive;
	} out_t;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] kp;
		logic signed [15:0] ki;
		logic signed [15:0] kd;
		logic signed [15:0] out_min;
		logic signed [15:0] out_max;
		logic signed [15:0] integ_min;
		logic signed [15:0] integ_max;
	} cfg_t;

	typedef struct packed {
		logic signed [16:0] last_err;
		logic signed [16:0] prev_err;
		logic signed [15:0] integral;
		logic signed [15:0] out_acc;
	} state_t;

	// The lower limit is applied first, so inverted limits yield the upper one.
	function automatic logic signed [15:0] clamp16(
		input logic signed [31:0] v,
		input logic signed [15:0] lo,
		input logic signed [15:0] hi
	);
		logic signed [31:0] t;
		t = v;
		if (t < 32'(lo)) begin
			t = 32'(lo);
		end
		if (t > 32'(hi)) begin
			t = 32'(hi);
		end
		return t[15:0];
	endfunction

endpackage

>>> rtl/core/pidc_datapath.sv
// ----------------------------------------------------------------------------
// pidc_datapath: one control update
// Forms the error, the three gain products and the saturated sums for the
// selected form, and returns the result word with the next loop state.
// ----------------------------------------------------------------------------
module pidc_datapath (
	input  pidc_pkg::cfg_t   cfg,
	input  pidc_pkg::state_t st,
	input  pidc_pkg::in_t    sample,
	output pidc_pkg::out_t   result,
	output pidc_pkg::state_t st_next
);
	import pidc_pkg::*;

	logic signed [16:0] err;
	logic signed [17:0] err_d1;
	logic signed [18:0] err_d2;
	logic signed [17:0] p_op;
	logic signed [18:0] d_op;
	logic signed [33:0] prod_p;
	logic signed [32:0] prod_i;
	logic signed [34:0] prod_d;
	logic signed [31:0] term_p;
	logic signed [31:0] term_i;
	logic signed [31:0] term_d;
	logic signed [31:0] sum_inc;
	logic signed [31:0] sum_integ;
	logic signed [31:0] sum_pos;
	logic signed [15:0] drive_inc;
	logic signed [15:0] integ_new;
	logic signed [15:0] drive_pos;

	always_comb begin
		err    = 17'(sample.setpoint) - 17'(sample.measured);
		err_d1 = 18'(err) - 18'(st.last_err);
		err_d2 = 19'(err) - (19'(st.last_err) <<< 1) + 19'(st.prev_err);

		// Positional form uses the error and its first difference; the
		// incremental form moves one difference further along.
		p_op = (cfg.mode == MODE_POS) ? 18'(err) : err_d1;
		d_op = (cfg.mode == MODE_POS) ? 19'(err_d1) : err_d2;

		prod_p = 34'(cfg.kp) * 34'(p_op);
		prod_i = 33'(cfg.ki) * 33'(err);
		prod_d = 35'(cfg.kd) * 35'(d_op);

		term_p = 32'(prod_p >>> 8);
		term_i = 32'(prod_i >>> 8);
		term_d = 32'(prod_d >>> 8);

		sum_inc   = 32'(st.out_acc) + term_p + term_i + term_d;
		drive_inc = clamp16(sum_inc, cfg.out_min, cfg.out_max);

		sum_integ = 32'(st.integral) + term_i;
		integ_new = clamp16(sum_integ, cfg.integ_min, cfg.integ_max);
		sum_pos   = term_p + 32'(integ_new) + term_d;
		drive_pos = clamp16(sum_pos, cfg.out_min, cfg.out_max);

		st_next          = st;
		st_next.last_err = err;
		if (cfg.mode == MODE_POS) begin
			st_next.integral = integ_new;
			st_next.out_acc  = drive_pos;
		end else begin
			st_next.prev_err = st.last_err;
			st_next.out_acc  = drive_inc;
		end

		result.error_value = err;
		result.drive       = st_next.out_acc;
	end

endmodule

>>> rtl/core/pid_controller_two_form.sv
// ----------------------------------------------------------------------------
// pid_controller_two_form: PID controller, incremental or positional form
// Registers each sample, computes the error and clamped drive combinationally
// and holds the result in an output register.
//
//   channel   signals                      direction  word
//   in        in_valid in_ready in_data    into       setpoint, measured
//   out       out_valid out_ready out_data out of     error_value, drive
//   cfg       cfg_we cfg_idx cfg_data      into       one register per write
//
// An accepted word passes the input register and then the output register, and
// one word is taken every cycle while the output does not stall.
// Reset clears the loop state and loads the default gains and limits.
// A stalled output holds the word in the input register; input stalls only
// when both registers are full.
// ----------------------------------------------------------------------------
module pid_controller_two_form (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  pidc_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pidc_pkg::out_t                      out_data,
	input  logic                                cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pidc_pkg::*;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_next;
	in_t    sample_s1;
	logic   valid_s1;
	out_t   out_q;
	out_t   result;
	logic   out_valid_q;
	logic   advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_INCR;
			cfg_q.kp        <= '0;
			cfg_q.ki        <= '0;
			cfg_q.kd        <= '0;
			cfg_q.out_min   <= LIMIT_LO;
			cfg_q.out_max   <= LIMIT_HI;
			cfg_q.integ_min <= LIMIT_LO;
			cfg_q.integ_max <= LIMIT_HI;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:      cfg_q.mode      <= cfg_data[0];
				REG_KP:        cfg_q.kp        <= cfg_data;
				REG_KI:        cfg_q.ki        <= cfg_data;
				REG_KD:        cfg_q.kd        <= cfg_data;
				REG_OUT_MIN:   cfg_q.out_min   <= cfg_data;
				REG_OUT_MAX:   cfg_q.out_max   <= cfg_data;
				REG_INTEG_MIN: cfg_q.integ_min <= cfg_data;
				REG_INTEG_MAX: cfg_q.integ_max <= cfg_data;
				default:       cfg_q.mode      <= cfg_q.mode;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_data;
		end
	end

	pidc_datapath u_datapath (
		.cfg     (cfg_q),
		.st      (state_q),
		.sample  (sample_s1),
		.result  (result),
		.st_next (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_next;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	// The error of the word on the output is the one the next update differences.
	a_last_err_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q.last_err == out_q.error_value)
		else $error("last error differs from the error on the output");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |=> valid_s1)
		else $error("input register dropped a word during an output stall");

	a_incr_shifts_history: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cfg_q.mode == MODE_INCR) |=>
			state_q.prev_err == $past(state_q.last_err))
		else $error("incremental update did not shift the error history");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("output word appeared without a registered input");

endmodule
